/* rtl/core/nns_pkg.sv */
// shared types and constants for the nearest-neighbor scaler
// no dependencies
package nns_pkg;

    localparam int MAX_WIDTH = 4096;                  // line buffer depth in pixels
    localparam int BUF_AW    = $clog2(MAX_WIDTH);     // line buffer address width
    localparam int ROWLEN_W  = BUF_AW + 1;            // holds a row length up to MAX_WIDTH
    localparam int PIX_W     = 24;                    // bgr pixel
    localparam int QDEPTH    = 4;                     // result queue entries
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_EMIT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_BUSY      = 3'd2,
        ST_EMITTED   = 3'd3,
        ST_NOT_READY = 3'd4
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_IN_WIDTH       = 3'd0,
        CFG_IN_HEIGHT      = 3'd1,
        CFG_OUT_WIDTH      = 3'd2,
        CFG_OUT_HEIGHT     = 3'd3,
        CFG_COL_STEP_WHOLE = 3'd4,
        CFG_COL_STEP_REM   = 3'd5,
        CFG_ROW_STEP_WHOLE = 3'd6,
        CFG_ROW_STEP_REM   = 3'd7
    } t_cfg_idx;

    // result descriptor from the front, without the pixel
    typedef struct packed {
        t_status    status;
        logic       row_end;
        logic       frame_end;
        logic [1:0] pad_bytes;
    } t_desc;

    // one complete result as held in the queue
    typedef struct packed {
        t_desc             desc;
        logic [PIX_W-1:0]  pixel;
    } t_result;

endpackage

/* rtl/core/nearest_neighbor_scaler.sv */
// top level of the nearest-neighbor scaler: stream ports, config port, line buffer
// depends on nns_pkg, nns_front, nns_ram, nns_queue
//
// Streams 24-bit bgr commands in and one result per command out. A load command
// (tuser 0) offers the next raster pixel: pixels of the source row needed next are
// written to a 4096-entry line buffer, others are skipped, and loads are refused
// while the buffer still serves output rows. An emit command (tuser 1) returns the
// next output pixel, picked by exact quotient/remainder stepping of
// floor(index*in/out) for rows and columns, with row end on tlast and the bmp pad
// byte count in tdata bits 25:24, just above the pixel bytes. One command is taken
// every clock while the result queue has room; each result passes the line buffer's
// registered read port and then the four-entry result queue, which absorbs output
// stalls until it fills, then holds off the input. The line buffer has no reset and
// no clearing pass.
// Write configuration only while no command is in flight.
module nearest_neighbor_scaler
    import nns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    // command stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [23:0]       i_s_axis_tdata,    // in_blue, in_green, in_red
    input  logic [0:0]        i_s_axis_tuser,    // command
    // result stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,    // out_blue, out_green, out_red, pad_bytes, zeros
    output logic [3:0]        o_m_axis_tuser,    // status, frame_end
    output logic              o_m_axis_tlast     // row_end
);

    logic              ram_we, ram_re;
    logic [BUF_AW-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    logic              desc_vld;
    t_desc             desc;
    logic              q_room;
    t_result           q_in, q_out;

    nns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vld       (i_s_axis_tvalid),
        .o_rdy       (o_s_axis_tready),
        .i_cmd       (t_cmd'(i_s_axis_tuser[0])),
        .i_pixel     (i_s_axis_tdata),
        .i_room      (q_room),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_desc_vld  (desc_vld),
        .o_desc      (desc)
    );

    // line buffer holding one source row
    nns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // pixel bytes read as zero unless the result is an emitted pixel
    assign q_in.desc  = desc;
    assign q_in.pixel = (desc.status == ST_EMITTED) ? ram_rdata : '0;

    nns_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_inflight (desc_vld),
        .o_room     (q_room),
        .i_push     (desc_vld),
        .i_data     (q_in),
        .o_vld      (o_m_axis_tvalid),
        .i_rdy      (i_m_axis_tready),
        .o_data     (q_out)
    );

    assign o_m_axis_tdata = {6'd0, q_out.desc.pad_bytes, q_out.pixel};
    assign o_m_axis_tuser = {q_out.desc.frame_end, q_out.desc.status};
    assign o_m_axis_tlast = q_out.desc.row_end;

endmodule

/* rtl/core/nns_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module nns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/nns_front.sv */
// front end: config registers, command classification, row/column stepping
// depends on nns_pkg; drives the line buffer ram ports
module nns_front
    import nns_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                i_vld,
    output logic                o_rdy,
    input  t_cmd                i_cmd,
    input  logic [PIX_W-1:0]    i_pixel,
    input  logic                i_room,
    output logic                o_ram_we,
    output logic [BUF_AW-1:0]   o_ram_waddr,
    output logic [PIX_W-1:0]    o_ram_wdata,
    output logic                o_ram_re,
    output logic [BUF_AW-1:0]   o_ram_raddr,
    output logic                o_desc_vld,
    output t_desc               o_desc
);

    // configuration
    logic [12:0] r_in_width, r_col_step_whole;
    logic [15:0] r_in_height, r_out_width, r_out_height;
    logic [15:0] r_col_step_rem, r_row_step_whole, r_row_step_rem;

    // load and emit state
    logic [BUF_AW-1:0] r_load_col, n_load_col;
    logic [15:0]       r_load_row, n_load_row;
    logic [15:0]       r_target_row, n_target_row;
    logic [15:0]       r_target_rem, n_target_rem;
    logic              r_buffer_full, n_buffer_full;
    logic [15:0]       r_emit_col, n_emit_col;
    logic [15:0]       r_emit_row, n_emit_row;
    logic [BUF_AW-1:0] r_src_col, n_src_col;
    logic [15:0]       r_src_rem, n_src_rem;

    logic  r_desc_vld;
    t_desc r_desc, n_desc;

    logic                accept;
    logic [ROWLEN_W-1:0] row_len;
    logic [ROWLEN_W-1:0] col_inc;
    logic                load_last;
    logic [16:0]         row_inc;
    logic                is_target;
    logic [16:0]         ecol_inc, erow_inc;
    logic                rend, fend;
    logic [16:0]         src_rem_sum, tgt_rem_sum;
    logic                src_ovf, tgt_ovf;
    logic [BUF_AW-1:0]   src_col_step;
    logic [15:0]         tgt_row_step;

    assign o_rdy  = i_room;
    assign accept = i_vld && i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width       <= 13'd1;
            r_in_height      <= 16'd1;
            r_out_width      <= 16'd1;
            r_out_height     <= 16'd1;
            r_col_step_whole <= 13'd1;
            r_col_step_rem   <= 16'd0;
            r_row_step_whole <= 16'd1;
            r_row_step_rem   <= 16'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_IN_WIDTH:       r_in_width       <= i_cfg_wdata[12:0];
                CFG_IN_HEIGHT:      r_in_height      <= i_cfg_wdata;
                CFG_OUT_WIDTH:      r_out_width      <= i_cfg_wdata;
                CFG_OUT_HEIGHT:     r_out_height     <= i_cfg_wdata;
                CFG_COL_STEP_WHOLE: r_col_step_whole <= i_cfg_wdata[12:0];
                CFG_COL_STEP_REM:   r_col_step_rem   <= i_cfg_wdata;
                CFG_ROW_STEP_WHOLE: r_row_step_whole <= i_cfg_wdata;
                CFG_ROW_STEP_REM:   r_row_step_rem   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        // effective row length: zero acts as one, capped at the buffer depth
        if (r_in_width == 13'd0) begin
            row_len = ROWLEN_W'(1);
        end else if (ROWLEN_W'(r_in_width) > ROWLEN_W'(MAX_WIDTH)) begin
            row_len = ROWLEN_W'(MAX_WIDTH);
        end else begin
            row_len = ROWLEN_W'(r_in_width);
        end
        col_inc   = ROWLEN_W'(r_load_col) + ROWLEN_W'(1);
        load_last = (col_inc >= row_len);
        row_inc   = {1'b0, r_load_row} + 17'd1;
        is_target = (r_load_row == r_target_row);

        ecol_inc = {1'b0, r_emit_col} + 17'd1;
        erow_inc = {1'b0, r_emit_row} + 17'd1;
        rend     = (ecol_inc >= {1'b0, r_out_width});
        fend     = rend && (erow_inc >= {1'b0, r_out_height});

        // exact rational stepping: whole part plus one conditional carry
        src_col_step = r_src_col + r_col_step_whole[BUF_AW-1:0];
        src_rem_sum  = {1'b0, r_src_rem} + {1'b0, r_col_step_rem};
        src_ovf      = (src_rem_sum >= {1'b0, r_out_width});
        tgt_row_step = r_target_row + r_row_step_whole;
        tgt_rem_sum  = {1'b0, r_target_rem} + {1'b0, r_row_step_rem};
        tgt_ovf      = (tgt_rem_sum >= {1'b0, r_out_height});

        n_load_col    = r_load_col;
        n_load_row    = r_load_row;
        n_target_row  = r_target_row;
        n_target_rem  = r_target_rem;
        n_buffer_full = r_buffer_full;
        n_emit_col    = r_emit_col;
        n_emit_row    = r_emit_row;
        n_src_col     = r_src_col;
        n_src_rem     = r_src_rem;
        n_desc        = '{status: ST_NOT_READY, row_end: 1'b0, frame_end: 1'b0,
                          pad_bytes: 2'd0};
        o_ram_we      = 1'b0;
        o_ram_re      = 1'b0;

        if (accept) begin
            if (i_cmd == CMD_LOAD) begin
                if (r_buffer_full) begin
                    n_desc.status = ST_BUSY;
                end else begin
                    n_desc.status = is_target ? ST_STORED : ST_SKIPPED;
                    o_ram_we      = is_target;
                    if (load_last) begin
                        n_load_col = '0;
                        if (is_target) begin
                            n_buffer_full = 1'b1;
                        end
                        n_load_row = (row_inc >= {1'b0, r_in_height}) ? 16'd0 : row_inc[15:0];
                    end else begin
                        n_load_col = col_inc[BUF_AW-1:0];
                    end
                end
            end else begin
                if (r_buffer_full) begin
                    o_ram_re         = 1'b1;
                    n_desc.status    = ST_EMITTED;
                    n_desc.row_end   = rend;
                    n_desc.frame_end = fend;
                    n_desc.pad_bytes = rend ? r_out_width[1:0] : 2'd0;
                    if (!rend) begin
                        n_emit_col = ecol_inc[15:0];
                        n_src_col  = src_col_step + BUF_AW'(src_ovf);
                        n_src_rem  = src_ovf ? 16'(src_rem_sum - {1'b0, r_out_width})
                                             : src_rem_sum[15:0];
                    end else begin
                        n_emit_col = '0;
                        n_src_col  = '0;
                        n_src_rem  = '0;
                        if (fend) begin
                            n_emit_row    = '0;
                            n_target_row  = '0;
                            n_target_rem  = '0;
                            n_buffer_full = 1'b0;
                        end else begin
                            n_emit_row   = erow_inc[15:0];
                            n_target_row = tgt_row_step + 16'(tgt_ovf);
                            n_target_rem = tgt_ovf ? 16'(tgt_rem_sum - {1'b0, r_out_height})
                                                   : tgt_rem_sum[15:0];
                            // a new source row must be loaded before emitting again
                            if (n_target_row != r_target_row) begin
                                n_buffer_full = 1'b0;
                            end
                        end
                    end
                end else begin
                    n_desc.status = ST_NOT_READY;
                end
            end
        end
    end

    assign o_ram_waddr = r_load_col;
    assign o_ram_wdata = i_pixel;
    assign o_ram_raddr = r_src_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col    <= '0;
            r_load_row    <= '0;
            r_target_row  <= '0;
            r_target_rem  <= '0;
            r_buffer_full <= 1'b0;
            r_emit_col    <= '0;
            r_emit_row    <= '0;
            r_src_col     <= '0;
            r_src_rem     <= '0;
            r_desc_vld    <= 1'b0;
        end else begin
            r_load_col    <= n_load_col;
            r_load_row    <= n_load_row;
            r_target_row  <= n_target_row;
            r_target_rem  <= n_target_rem;
            r_buffer_full <= n_buffer_full;
            r_emit_col    <= n_emit_col;
            r_emit_row    <= n_emit_row;
            r_src_col     <= n_src_col;
            r_src_rem     <= n_src_rem;
            r_desc_vld    <= accept;
        end
    end

    // descriptor is registered alongside the ram read data, so the two line up
    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
    end

    assign o_desc_vld = r_desc_vld;
    assign o_desc     = r_desc;

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("line buffer written and read in one cycle");

    a_write_only_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (!r_buffer_full && is_target))
        else $error("line buffer written while full or off target row");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_EMIT && r_buffer_full && fend) |=> !r_buffer_full)
        else $error("buffer still full after frame end");

    a_emitted_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_EMIT && r_buffer_full) |=>
            (o_desc_vld && o_desc.status == ST_EMITTED))
        else $error("emit from full buffer did not report emitted");

endmodule

/* rtl/core/nns_queue.sv */
// short result queue between the front end and the output port
// depends on nns_pkg; counts in-flight descriptors against its free space
module nns_queue
    import nns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_inflight,
    output logic    o_room,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_vld,
    input  logic    i_rdy,
    output t_result o_data
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic             pop;
    logic [QCW:0]     used;

    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];
    assign pop    = o_vld && i_rdy;
    // room for one more item beyond those already accepted upstream
    assign used   = (QCW+1)'(r_count) + (QCW+1)'(i_inflight);
    assign o_room = (used < (QCW+1)'(QDEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + QCW'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCW'(QDEPTH) || pop))
        else $error("push into full result queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue count out of range");

    a_room_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_room && !i_inflight) |=> (i_push || r_count < QCW'(QDEPTH)))
        else $error("queue filled without reservation");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the nearest-neighbor scaler stream block
// needs nns_pkg and the scaler rtl; drives commands, config writes and checks every result
`timescale 1ns / 100ps

module testbench;
    import nns_pkg::*;

    // clock, reset and all block inputs start at known values
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic [23:0]       s_data    = '0;    // blue, green, red
    logic [0:0]        s_user    = '0;    // command
    logic              m_ready   = 1'b0;

    logic              s_ready;
    logic              m_valid;
    logic [31:0]       m_data;            // blue, green, red, pad_bytes, zeros
    logic [3:0]        m_user;            // status, frame_end
    logic              m_last;            // row_end

    nearest_neighbor_scaler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scaler prediction state, a private copy of the block's registers
    // ------------------------------------------------------------------
    logic [23:0] line_mem     [MAX_WIDTH];
    bit          line_written [MAX_WIDTH];   // guards against reading never-loaded entries

    logic [11:0] ld_col    = '0;   // next input column
    logic [15:0] ld_row    = '0;   // current input row
    logic [15:0] tgt_row   = '0;   // source row the next output row needs
    logic [15:0] tgt_rem   = '0;
    logic        row_ready = 1'b0; // line buffer holds the target row
    logic [15:0] em_col    = '0;   // output position
    logic [15:0] em_row    = '0;
    logic [11:0] src_col   = '0;   // source column of the next output pixel
    logic [15:0] src_rem   = '0;

    // register copies at their reset values
    logic [12:0] cfg_in_w      = 13'd1;
    logic [15:0] cfg_in_h      = 16'd1;
    logic [15:0] cfg_out_w     = 16'd1;
    logic [15:0] cfg_out_h     = 16'd1;
    logic [12:0] cfg_col_whole = 13'd1;
    logic [15:0] cfg_col_rem   = 16'd0;
    logic [15:0] cfg_row_whole = 16'd1;
    logic [15:0] cfg_row_rem   = 16'd0;

    // expected results in command order
    t_result     pending_results [$];

    int unsigned sent_items  = 0;
    int unsigned checked     = 0;
    int unsigned error_count = 0;
    int unsigned status_seen [8];

    // idle_pct paces both stream sides; hold and stall counts pace the result side
    int unsigned idle_pct   = 20;
    int          hold_left  = 0;
    int          stall_left = 0;

    // advance the scaler copy by one command and return what the block must answer
    function automatic t_result scale_predict(t_cmd cmd, logic [23:0] pix);
        t_result     res;
        int unsigned row_len;
        int unsigned acc;
        logic        hit;
        logic        last_col;
        logic        last_row;
        logic [15:0] prev_tgt;
        res = '0;
        if (cmd == CMD_LOAD) begin
            // zero width acts as one, rows longer than the buffer are cut
            row_len = (cfg_in_w == 0) ? 1 : 32'(cfg_in_w);
            if (row_len > MAX_WIDTH)
                row_len = MAX_WIDTH;
            if (row_ready) begin
                res.desc.status = ST_BUSY;
                return res;
            end
            hit = (ld_row == tgt_row);
            if (hit) begin
                line_mem[ld_col]     = pix;
                line_written[ld_col] = 1'b1;
                res.desc.status      = ST_STORED;
            end else begin
                res.desc.status = ST_SKIPPED;
            end
            if (ld_col + 1 >= row_len) begin
                ld_col = '0;
                if (hit)
                    row_ready = 1'b1;
                if (ld_row + 1 >= cfg_in_h)
                    ld_row = '0;
                else
                    ld_row = ld_row + 1'b1;
            end else begin
                ld_col = ld_col + 1'b1;
            end
            return res;
        end

        if (!row_ready) begin
            res.desc.status = ST_NOT_READY;
            return res;
        end
        last_col = (em_col + 1 >= cfg_out_w);
        last_row = last_col && (em_row + 1 >= cfg_out_h);
        res.desc.status    = ST_EMITTED;
        res.pixel          = line_mem[src_col];
        res.desc.row_end   = last_col;
        res.desc.frame_end = last_row;
        res.desc.pad_bytes = last_col ? cfg_out_w[1:0] : 2'd0;

        if (!last_col) begin
            // column step: whole part plus remainder with one conditional carry
            em_col  = em_col + 1'b1;
            src_col = 12'(src_col + cfg_col_whole);
            acc     = 32'(src_rem) + 32'(cfg_col_rem);
            if (acc >= cfg_out_w) begin
                acc     = acc - 32'(cfg_out_w);
                src_col = src_col + 1'b1;
            end
            src_rem = acc[15:0];
            return res;
        end
        em_col  = '0;
        src_col = '0;
        src_rem = '0;
        if (last_row) begin
            em_row    = '0;
            tgt_row   = '0;
            tgt_rem   = '0;
            row_ready = 1'b0;
            return res;
        end
        // row step, the buffer is only released when the source row moves
        em_row   = em_row + 1'b1;
        prev_tgt = tgt_row;
        tgt_row  = tgt_row + cfg_row_whole;
        acc      = 32'(tgt_rem) + 32'(cfg_row_rem);
        if (acc >= cfg_out_h) begin
            acc     = acc - 32'(cfg_out_h);
            tgt_row = tgt_row + 1'b1;
        end
        tgt_rem = acc[15:0];
        if (tgt_row != prev_tgt)
            row_ready = 1'b0;
        return res;
    endfunction

    // both cursors back at the top of a frame
    function automatic bit at_frame_start();
        return ld_col == 0 && ld_row == 0 && !row_ready && em_col == 0 && em_row == 0
            && tgt_row == 0;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // offer one command until it is taken; expectation is queued up front
    task automatic push_command(t_cmd cmd, logic [23:0] pix);
        t_result res;
        // an emit that would read a never-loaded buffer entry is not sent
        if (cmd == CMD_EMIT && row_ready && !line_written[src_col])
            return;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        res = scale_predict(cmd, pix);
        pending_results.push_back(res);
        s_valid <= 1'b1;
        s_data  <= pix;
        s_user  <= cmd;
        do
            @(posedge i_clk);
        while (!s_ready);
        sent_items++;
    endtask

    // well-formed traffic: load until the row is in, then emit; noise flips the choice
    task automatic stream_pixels(int unsigned n, int unsigned noise_pct);
        t_cmd cmd;
        repeat (n) begin
            if (row_ready)
                cmd = CMD_EMIT;
            else
                cmd = CMD_LOAD;
            if ($urandom_range(0, 99) < noise_pct) begin
                if (cmd == CMD_LOAD)
                    cmd = CMD_EMIT;
                else
                    cmd = CMD_LOAD;
            end
            push_command(cmd, 24'($urandom));
        end
    endtask

    // run well-formed traffic until both cursors wrap to the frame start
    task automatic complete_frame();
        int unsigned guard;
        guard = 0;
        while (!at_frame_start() && guard < 400000) begin
            stream_pixels(1, 0);
            guard++;
        end
    endtask

    // stop offering and wait for every outstanding transfer to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DW-1:0];
        case (idx)
            CFG_IN_WIDTH:       cfg_in_w      = value[12:0];
            CFG_IN_HEIGHT:      cfg_in_h      = value[15:0];
            CFG_OUT_WIDTH:      cfg_out_w     = value[15:0];
            CFG_OUT_HEIGHT:     cfg_out_h     = value[15:0];
            CFG_COL_STEP_WHOLE: cfg_col_whole = value[12:0];
            CFG_COL_STEP_REM:   cfg_col_rem   = value[15:0];
            CFG_ROW_STEP_WHOLE: cfg_row_whole = value[15:0];
            CFG_ROW_STEP_REM:   cfg_row_rem   = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // program all eight registers once the block is quiet
    task automatic set_scaling(int unsigned iw, int unsigned ih, int unsigned ow,
                               int unsigned oh, int unsigned cw, int unsigned cr,
                               int unsigned rw, int unsigned rr);
        drain_results();
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_COL_STEP_WHOLE, cw);
        write_reg(CFG_COL_STEP_REM, cr);
        write_reg(CFG_ROW_STEP_WHOLE, rw);
        write_reg(CFG_ROW_STEP_REM, rr);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall bursts plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
                stall_left = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each result transfer against the oldest expectation
    t_result want_res;
    logic    bad;

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            status_seen[m_user[2:0]]++;
            if (pending_results.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result transfer: tdata %08h tuser %h tlast %0b",
                             m_data, m_user, m_last);
                error_count++;
            end else begin
                want_res = pending_results.pop_front();
                checked++;
                bad = (m_user[2:0] != want_res.desc.status)
                   || (m_data[23:0] != want_res.pixel)
                   || (m_last != want_res.desc.row_end)
                   || (m_user[3] != want_res.desc.frame_end)
                   || (m_data[25:24] != want_res.desc.pad_bytes)
                   || (m_data[31:26] != '0);
                if (bad) begin
                    if (error_count < 10) begin
                        $display("result %0d expected: st %0d pix %06h rend %0b fend %0b pad %0d",
                                 checked, want_res.desc.status, want_res.pixel,
                                 want_res.desc.row_end, want_res.desc.frame_end,
                                 want_res.desc.pad_bytes);
                        $display("  got: st %0d pix %06h rend %0b fend %0b pad %0d high %02h",
                                 m_user[2:0], m_data[23:0], m_last, m_user[3],
                                 m_data[25:24], m_data[31:26]);
                    end
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset sizes: one pixel in, one pixel out
    task automatic test_reset_config();
        push_command(CMD_EMIT, 24'h000000);    // nothing loaded yet
        push_command(CMD_LOAD, 24'hFFFFFF);    // all-ones pixel fills the row
        push_command(CMD_LOAD, 24'h123456);    // refused while the row is held
        push_command(CMD_EMIT, 24'h000000);    // row end, frame end, pad of one
        push_command(CMD_EMIT, 24'hFFFFFF);    // buffer released again
        push_command(CMD_LOAD, 24'h000000);
        push_command(CMD_EMIT, 24'hFFFFFF);
        repeat (4) begin
            push_command(CMD_LOAD, 24'($urandom));
            push_command(CMD_EMIT, 24'($urandom));
        end
    endtask

    // zero sizes: width acts as one, every row and every pixel closes the frame
    task automatic test_zero_sizes();
        set_scaling(0, 0, 0, 0, 0, 0, 0, 0);
        push_command(CMD_LOAD, 24'hA5A5A5);
        push_command(CMD_LOAD, 24'h5A5A5A);
        push_command(CMD_EMIT, 24'h000000);
        push_command(CMD_EMIT, 24'h000000);
        push_command(CMD_LOAD, 24'h0F0F0F);
        push_command(CMD_EMIT, 24'h000000);
        push_command(CMD_LOAD, 24'hF0F0F0);
        push_command(CMD_EMIT, 24'h000000);
    endtask

    // oversized remainders: one conditional subtraction per step, counters wrap
    task automatic test_remainder_wrap();
        set_scaling(8, 6, 5, 3, 0, 65535, 0, 65535);
        stream_pixels(150, 10);
        complete_frame();
    endtask

    // one output pixel per row with the largest column step value
    task automatic test_full_col_step();
        idle_pct = 0;
        set_scaling(40, 1, 1, 1, 8191, 0, 65535, 0);
        stream_pixels(1, 0);
        complete_frame();
    endtask

    // wide output row from a short input row, second input row skipped
    task automatic test_wide_rows();
        set_scaling(20, 2, 200, 1, 0, 20, 2, 0);
        stream_pixels(1, 0);
        complete_frame();
    endtask

    // random consistent ratios, with back-pressure and a full sender pause
    task automatic test_random_frames();
        int unsigned start;
        int unsigned phase;
        int unsigned iw;
        int unsigned ih;
        int unsigned ow;
        int unsigned oh;
        start = sent_items;
        phase = 0;
        while (sent_items - start < 600) begin
            if ($urandom_range(0, 7) == 0)
                iw = $urandom_range(13, 64);
            else
                iw = $urandom_range(1, 12);
            ih = $urandom_range(1, 6);
            ow = $urandom_range(1, 24);
            oh = $urandom_range(1, 8);
            set_scaling(iw, ih, ow, oh, iw / ow, iw % ow, ih / oh, ih % oh);
            if (phase % 4 == 3)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(5, 40);
            // long receiver hold-off: queue fills and the command side backs up
            if (phase == 1)
                hold_left = 300;
            stream_pixels($urandom_range(120, 200), 10);
            if (phase == 2) begin
                drain_results();
                stream_pixels(40, 10);
            end
            complete_frame();
            phase++;
        end
    endtask

    // tallest frame, a few rows only, no idling at the tail of the run
    task automatic test_tall_frame();
        idle_pct = 0;
        set_scaling(2, 65535, 3, 65535, 0, 2, 1, 0);
        stream_pixels(100, 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_zero_sizes();
        test_remainder_wrap();
        test_full_col_step();
        test_wide_rows();
        test_random_frames();
        test_tall_frame();

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("scaler run: %0d commands sent, %0d results checked, %0d errors",
                 sent_items, checked, error_count);
        $display("statuses seen: stored %0d skipped %0d busy %0d emitted %0d not ready %0d",
                 status_seen[ST_STORED], status_seen[ST_SKIPPED], status_seen[ST_BUSY],
                 status_seen[ST_EMITTED], status_seen[ST_NOT_READY]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
